// ===== rtl/stack_machine_exec_core_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef STACK_MACHINE_EXEC_CORE_MACROS_SVH
`define STACK_MACHINE_EXEC_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMX_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smx check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SMX_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smx check failed");

`endif

// ===== rtl/smx_pkg.sv =====
// Shared types, codes and helpers of the stack machine executor.
package smx_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int NUM_LOCALS = 16;
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int LIDX_W = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] A_I32CONST = 4'd0;
	localparam logic [3:0] A_I64CONST = 4'd1;
	localparam logic [3:0] A_ADD      = 4'd2;
	localparam logic [3:0] A_SUB      = 4'd3;
	localparam logic [3:0] A_MUL      = 4'd4;
	localparam logic [3:0] A_DIVS     = 4'd5;
	localparam logic [3:0] A_LGET     = 4'd6;
	localparam logic [3:0] A_LSET     = 4'd7;
	localparam logic [3:0] A_RETURN   = 4'd8;
	localparam logic [3:0] A_DROP     = 4'd9;
	localparam logic [3:0] A_NOP      = 4'd10;
	localparam logic [3:0] A_RESTART  = 4'd11;

	localparam logic [2:0] K_PUSHC   = 3'd0;
	localparam logic [2:0] K_BIN     = 3'd1;
	localparam logic [2:0] K_LGET    = 3'd2;
	localparam logic [2:0] K_LSET    = 3'd3;
	localparam logic [2:0] K_RET     = 3'd4;
	localparam logic [2:0] K_DROP    = 3'd5;
	localparam logic [2:0] K_NOP     = 3'd6;
	localparam logic [2:0] K_RESTART = 3'd7;

	localparam logic [1:0] BIN_ADD = 2'd0;
	localparam logic [1:0] BIN_SUB = 2'd1;
	localparam logic [1:0] BIN_MUL = 2'd2;
	localparam logic [1:0] BIN_DIV = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_STOPPED   = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;
	localparam logic [2:0] ST_BADLOCAL  = 3'd5;
	localparam logic [2:0] ST_BADOP     = 3'd6;
	localparam logic [2:0] ST_IGNORED   = 3'd7;

	localparam logic [1:0] RS_READY   = 2'd0;
	localparam logic [1:0] RS_RUNNING = 2'd1;
	localparam logic [1:0] RS_STOPPED = 2'd2;
	localparam logic [1:0] RS_ERROR   = 2'd3;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [63:0] operand;
		logic               last_instruction;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] top_value;
		logic [10:0] stack_depth;
		logic [1:0]  run_state;
		logic [31:0] instr_count;
	} res_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [1:0]        bin_op;
		logic              bad_op;
		logic [63:0]       value;
		logic [LIDX_W-1:0] lidx;
		logic              bad_idx;
		logic              last;
	} cmd_t;

	function automatic logic [63:0] sext32(logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

// ===== rtl/smx_front.sv =====
// Front end: decodes incoming instructions and queues them for execution.
module smx_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  smx_pkg::item_t item,
	output logic           cmd_valid,
	input  logic           cmd_pop,
	output smx_pkg::cmd_t  cmd
);
	import smx_pkg::*;

	cmd_t              dec;
	cmd_t              q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;

	always_comb begin
		dec = '0;
		dec.last = item.last_instruction;
		dec.lidx = item.operand[LIDX_W-1:0];
		dec.bad_idx = item.operand[31:0] >= 32'(NUM_LOCALS);
		dec.value = item.operand;
		unique case (item.action)
			A_I32CONST: begin
				dec.kind = K_PUSHC;
				dec.value = sext32(item.operand[31:0]);
			end
			A_I64CONST: dec.kind = K_PUSHC;
			A_ADD: begin
				dec.kind = K_BIN;
				dec.bin_op = BIN_ADD;
			end
			A_SUB: begin
				dec.kind = K_BIN;
				dec.bin_op = BIN_SUB;
			end
			A_MUL: begin
				dec.kind = K_BIN;
				dec.bin_op = BIN_MUL;
			end
			A_DIVS: begin
				dec.kind = K_BIN;
				dec.bin_op = BIN_DIV;
			end
			A_LGET:    dec.kind = K_LGET;
			A_LSET:    dec.kind = K_LSET;
			A_RETURN:  dec.kind = K_RET;
			A_DROP:    dec.kind = K_DROP;
			A_NOP:     dec.kind = K_NOP;
			A_RESTART: dec.kind = K_RESTART;
			default: begin
				dec.kind = K_NOP;
				dec.bad_op = 1'b1;
			end
		endcase
	end

	assign full = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign wr_en = push && !full;
	assign cmd_valid = cnt_q != '0;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(wr_en) - QCNT_W'(cmd_pop);
		end
	end

endmodule

// ===== rtl/smx_div.sv =====
// Signed 32-bit divider, one quotient bit per cycle, truncating.
module smx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import smx_pkg::*;

	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic        fin_q;
	logic        neg_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;

	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign done = fin_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!rem_sub[32]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/smx_back.sv =====
// Back end: executes queued instructions on the stack memory and locals.
module smx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  smx_pkg::cmd_t cmd,
	input  logic          res_full,
	output logic          res_push,
	output smx_pkg::res_t res
);
	import smx_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDPOP = 3'd1;
	localparam logic [2:0] S_RDA   = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_WB    = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]         state_q;
	logic [DEPTH_W-1:0] count_q;
	logic [63:0]        tos_q;
	logic [1:0]         rs_q;
	logic [31:0]        steps_q;
	logic [2:0]         status_q;
	logic               stop_q;
	logic [1:0]         binop_q;
	logic [31:0]        a_q;
	logic [31:0]        b_q;
	logic [31:0]        res_q;
	logic [NUM_LOCALS-1:0] lval_q;
	logic [63:0]        locals_q [NUM_LOCALS];
	logic [63:0]        mem [STACK_DEPTH];
	logic [63:0]        rd_q;

	logic               start;
	logic               active;
	logic               stk_full;
	logic               stk_empty;
	logic [DEPTH_W-1:0] cnt_m1;
	logic [DEPTH_W-1:0] cnt_m2;
	logic [DEPTH_W-1:0] cnt_m3;
	logic               ex_ok;
	logic               ex_fail;
	logic [2:0]         ex_code;
	logic               ex_stop;
	logic               do_push;
	logic               do_lset;
	logic [63:0]        lget_val;
	logic [63:0]        push_val;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [63:0]        mem_wd;
	logic [ADDR_W-1:0]  mem_ra;
	logic               div_go;
	logic               div_done;
	logic [31:0]        div_q;

	assign start = (state_q == S_IDLE) && cmd_valid && !res_full;
	assign cmd_pop = start;
	assign active = (rs_q == RS_READY) || (rs_q == RS_RUNNING);
	assign stk_full = count_q == DEPTH_W'(STACK_DEPTH);
	assign stk_empty = count_q == '0;
	assign cnt_m1 = count_q - DEPTH_W'(1);
	assign cnt_m2 = count_q - DEPTH_W'(2);
	assign cnt_m3 = count_q - DEPTH_W'(3);
	assign ex_stop = cmd.last || (cmd.kind == K_RET);
	assign lget_val = lval_q[cmd.lidx] ? locals_q[cmd.lidx] : 64'd0;
	assign push_val = (cmd.kind == K_LGET) ? lget_val : cmd.value;

	always_comb begin
		ex_ok = 1'b0;
		ex_fail = 1'b0;
		ex_code = ST_OK;
		if (cmd.bad_op) begin
			ex_fail = 1'b1;
			ex_code = ST_BADOP;
		end else begin
			unique case (cmd.kind)
				K_PUSHC: begin
					ex_fail = stk_full;
					ex_code = ST_OVERFLOW;
				end
				K_LGET: begin
					ex_fail = cmd.bad_idx || stk_full;
					ex_code = cmd.bad_idx ? ST_BADLOCAL : ST_OVERFLOW;
				end
				K_LSET: begin
					ex_fail = cmd.bad_idx || stk_empty;
					ex_code = cmd.bad_idx ? ST_BADLOCAL : ST_UNDERFLOW;
				end
				K_DROP: begin
					ex_fail = stk_empty;
					ex_code = ST_UNDERFLOW;
				end
				K_BIN: begin
					ex_fail = count_q < DEPTH_W'(2);
					ex_code = ST_UNDERFLOW;
				end
				K_RET, K_NOP, K_RESTART: ex_fail = 1'b0;
				default: ex_fail = 1'b0;
			endcase
			ex_ok = !ex_fail && (cmd.kind != K_BIN);
		end
	end

	assign do_push = start && active && (cmd.kind != K_RESTART) && ex_ok
		&& ((cmd.kind == K_PUSHC) || (cmd.kind == K_LGET));
	assign do_lset = start && active && (cmd.kind == K_LSET) && ex_ok;

	always_comb begin
		mem_we = do_push || (state_q == S_WB);
		mem_wa = (state_q == S_WB) ? cnt_m2[ADDR_W-1:0] : count_q[ADDR_W-1:0];
		mem_wd = (state_q == S_WB) ? sext32(res_q) : push_val;
		mem_ra = (state_q == S_RDA) ? cnt_m3[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
	end

	assign div_go = (state_q == S_RDA) && (binop_q == BIN_DIV) && (b_q != 32'd0);

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (rd_q[31:0]),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
		if (do_lset) begin
			locals_q[cmd.lidx] <= tos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rs_q <= RS_READY;
			steps_q <= '0;
			lval_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_FIN;
						if (cmd.kind == K_RESTART && !cmd.bad_op) begin
							count_q <= '0;
							lval_q <= '0;
							steps_q <= '0;
							rs_q <= RS_READY;
							status_q <= ST_OK;
						end else if (!active) begin
							status_q <= ST_IGNORED;
						end else begin
							rs_q <= RS_RUNNING;
							stop_q <= cmd.last;
							binop_q <= cmd.bin_op;
							b_q <= tos_q[31:0];
							if (ex_fail) begin
								rs_q <= RS_ERROR;
								status_q <= ex_code;
								if (cmd.kind == K_BIN && !stk_empty) begin
									count_q <= '0;
								end
							end
							if (ex_ok) begin
								steps_q <= steps_q + 32'd1;
								if (ex_stop) begin
									rs_q <= RS_STOPPED;
									status_q <= ST_STOPPED;
								end else begin
									status_q <= ST_OK;
								end
							end
							if (do_push) begin
								tos_q <= push_val;
								count_q <= count_q + DEPTH_W'(1);
							end
							if (ex_ok && (cmd.kind == K_LSET || cmd.kind == K_DROP)) begin
								count_q <= cnt_m1;
								state_q <= S_RDPOP;
							end
							if (cmd.kind == K_BIN && !ex_fail) begin
								state_q <= S_RDA;
							end
							if (do_lset) begin
								lval_q[cmd.lidx] <= 1'b1;
							end
						end
					end
				end
				S_RDPOP: begin
					tos_q <= rd_q;
					state_q <= S_FIN;
				end
				S_RDA: begin
					unique case (binop_q)
						BIN_ADD: begin
							res_q <= rd_q[31:0] + b_q;
							state_q <= S_WB;
						end
						BIN_SUB: begin
							res_q <= rd_q[31:0] - b_q;
							state_q <= S_WB;
						end
						BIN_MUL: begin
							a_q <= rd_q[31:0];
							state_q <= S_MUL;
						end
						BIN_DIV: begin
							if (b_q == 32'd0) begin
								count_q <= cnt_m2;
								rs_q <= RS_ERROR;
								status_q <= ST_DIVZERO;
								state_q <= S_RDPOP;
							end else begin
								state_q <= S_DIV;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_MUL: begin
					res_q <= a_q * b_q;
					state_q <= S_WB;
				end
				S_DIV: begin
					if (div_done) begin
						res_q <= div_q;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					tos_q <= sext32(res_q);
					count_q <= cnt_m1;
					steps_q <= steps_q + 32'd1;
					if (stop_q) begin
						rs_q <= RS_STOPPED;
						status_q <= ST_STOPPED;
					end else begin
						status_q <= ST_OK;
					end
					state_q <= S_FIN;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_push = state_q == S_FIN;

	always_comb begin
		res.status = status_q;
		res.top_value = stk_empty ? 64'd0 : tos_q;
		res.stack_depth = 11'(count_q);
		res.run_state = rs_q;
		res.instr_count = steps_q;
	end

endmodule

// ===== rtl/smx_resq.sv =====
// Result queue: holds finished result beats until they are popped.
module smx_resq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  smx_pkg::res_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output smx_pkg::res_t result
);
	import smx_pkg::*;

	res_t              q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              rd_en;

	assign full = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_en = pop && !empty;
	assign result = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd_en);
		end
	end

endmodule

// ===== rtl/stack_machine_exec_core.sv =====
// Top level of the stack machine executor.
// Input channel: drive item and raise push; the beat is taken on a clock edge
// where push is high and full is low. Each beat is one instruction.
// Result channel: while empty is low, result holds the oldest result beat;
// it is taken on a clock edge where pop is high. Every instruction gives
// exactly one result beat, in order.
// A two-entry command queue sits between decode and execution, and a
// two-entry result queue after execution, so a stalled receiver does not
// stop instructions from being taken until both queues fill.
// Execution sequencer: push, local get, return, nop, restart, ignored beats
// and failed ops go straight to the finish state; drop and local set first
// read the new top from stack memory; add and sub read the stack memory and
// write back, mul adds a registered multiply before write back, divide by
// zero reads the stack memory and then the new top, and divide waits for the
// one-bit-per-cycle divider. Each result beat then passes the result queue.
// Reset (arst_n low) empties both queues, zeroes the stack depth, locals and
// instruction count, and sets the run state to ready. Stack memory contents
// are not cleared; only entries written by a push are ever read.
module stack_machine_exec_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  smx_pkg::item_t item,
	output logic           empty,
	input  logic           pop,
	output smx_pkg::res_t  result
);
	import smx_pkg::*;

	cmd_t cmd;
	res_t res;
	logic cmd_valid;
	logic cmd_pop;
	logic res_full;
	logic res_push;

	smx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	smx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	smx_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res),
		.full    (res_full),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ===== rtl/smx_check.sv =====
// Port-level checker for the stack machine executor, bound to the top level.
`include "stack_machine_exec_core_macros.svh"

module smx_check (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input smx_pkg::res_t  result
);
	import smx_pkg::*;

	`SMX_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(result))
	`SMX_ASSERT_IMP(a_stop_state, !empty && result.status == ST_STOPPED, result.run_state == RS_STOPPED)
	`SMX_ASSERT_IMP(a_empty_top, !empty && result.stack_depth == 11'd0, result.top_value == 64'd0)
	`SMX_ASSERT_IMP(a_ignored, !empty && result.status == ST_IGNORED, result.run_state == RS_STOPPED || result.run_state == RS_ERROR)

endmodule

bind stack_machine_exec_core smx_check u_check (.*);

// ===== verif/stack_machine_exec_core_checker.sv =====
// Checker: watches both channels of the stack machine executor, predicts and compares results.
module stack_machine_exec_core_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  smx_pkg::item_t item,
	input  logic           empty,
	input  logic           pop,
	input  smx_pkg::res_t  result,
	output int             fail_count,
	output int             pending,
	output int             beats_seen
);
	import smx_pkg::*;

	logic [63:0] mstack [STACK_DEPTH];
	int          mdepth;
	logic [63:0] mlocals [NUM_LOCALS];
	logic [1:0]  mstate;
	logic [31:0] msteps;
	res_t        expected_q [$];

	function automatic logic [63:0] x32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [2:0] do_push(logic [63:0] v);
		if (mdepth >= STACK_DEPTH)
			return ST_OVERFLOW;
		mstack[mdepth] = v;
		mdepth++;
		return ST_OK;
	endfunction

	function automatic logic [2:0] do_pop(output logic [63:0] v);
		v = '0;
		if (mdepth == 0)
			return ST_UNDERFLOW;
		mdepth--;
		v = mstack[mdepth];
		return ST_OK;
	endfunction

	function automatic logic [2:0] run_op(item_t it, output logic ret);
		logic [63:0] a, b, v;
		logic [31:0] ua, ub, ma, mb, q;
		logic [31:0] idx;
		ret = 1'b0;
		idx = it.operand[31:0];
		case (it.action)
			A_I32CONST: return do_push(x32(it.operand));
			A_I64CONST: return do_push(it.operand);
			A_ADD, A_SUB, A_MUL, A_DIVS: begin
				if (do_pop(b) != ST_OK) return ST_UNDERFLOW;
				if (do_pop(a) != ST_OK) return ST_UNDERFLOW;
				case (it.action)
					A_ADD: v = x32(a + b);
					A_SUB: v = x32(a - b);
					A_MUL: v = x32(a[31:0] * b[31:0]);
					default: begin
						if (b[31:0] == 0) return ST_DIVZERO;
						ua = a[31:0];
						ub = b[31:0];
						ma = ua[31] ? -ua : ua;
						mb = ub[31] ? -ub : ub;
						q = ma / mb;
						if (ua[31] != ub[31]) q = -q;
						v = x32(q);
					end
				endcase
				return do_push(v);
			end
			A_LGET: begin
				if (idx >= NUM_LOCALS) return ST_BADLOCAL;
				return do_push(mlocals[idx]);
			end
			A_LSET: begin
				if (idx >= NUM_LOCALS) return ST_BADLOCAL;
				if (do_pop(v) != ST_OK) return ST_UNDERFLOW;
				mlocals[idx] = v;
				return ST_OK;
			end
			A_RETURN: begin
				ret = 1'b1;
				return ST_OK;
			end
			A_DROP: return do_pop(v);
			A_NOP: return ST_OK;
			default: return ST_BADOP;
		endcase
	endfunction

	function automatic res_t exec_instr(item_t it);
		res_t r;
		logic ret;
		if (it.action == A_RESTART) begin
			mdepth = 0;
			foreach (mlocals[i]) mlocals[i] = '0;
			msteps = '0;
			mstate = RS_READY;
			r.status = ST_OK;
		end else if (mstate == RS_STOPPED || mstate == RS_ERROR) begin
			r.status = ST_IGNORED;
		end else begin
			mstate = RS_RUNNING;
			r.status = run_op(it, ret);
			if (r.status != ST_OK) begin
				mstate = RS_ERROR;
			end else begin
				msteps++;
				if (ret || it.last_instruction) begin
					mstate = RS_STOPPED;
					r.status = ST_STOPPED;
				end
			end
		end
		r.top_value = mdepth ? mstack[mdepth-1] : '0;
		r.stack_depth = mdepth[10:0];
		r.run_state = mstate;
		r.instr_count = msteps;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		beats_seen = 0;
		mdepth = 0;
		mstate = RS_READY;
		msteps = '0;
		foreach (mlocals[i]) mlocals[i] = '0;
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (push && !full)
				expected_q.push_back(exec_instr(item));
			if (pop && !empty) begin
				beats_seen++;
				if (expected_q.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					e = expected_q.pop_front();
					if (result.status !== e.status)
						report("status", result.status, e.status);
					if (result.top_value !== e.top_value)
						report("top_value", result.top_value, e.top_value);
					if (result.stack_depth !== e.stack_depth)
						report("stack_depth", result.stack_depth, e.stack_depth);
					if (result.run_state !== e.run_state)
						report("run_state", result.run_state, e.run_state);
					if (result.instr_count !== e.instr_count)
						report("instr_count", result.instr_count, e.instr_count);
				end
			end
		end
	end
endmodule

// ===== verif/tb_stack_machine_exec_core.sv =====
// Testbench top: drives instruction beats into the stack machine executor and gives the verdict.
module tb_stack_machine_exec_core;
	import smx_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	item_t  item;
	logic   empty;
	logic   pop;
	res_t   result;
	int     fail_count;
	int     pending;
	int     beats_seen;
	int     cycles;
	logic   calm;
	int     sent;

	localparam int CYCLE_LIMIT = 900000;

	stack_machine_exec_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	stack_machine_exec_core_checker i_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .fail_count(fail_count),
		.pending(pending), .beats_seen(beats_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall bursts until the calm phase
	initial begin
		int n;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				pop <= 1'b0;
				repeat (n) @(negedge clk);
			end
			pop <= 1'b1;
		end
	end

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = 64'h8000_0000_0000_0000;
			1: v = 64'h7fff_ffff_ffff_ffff;
			2: v = '0;
			3: v = '1;
			4: v = {{32{v[31]}}, 32'h8000_0000};
			5: v = $urandom_range(0, 20);
			default: ;
		endcase
		return v;
	endfunction

	// push stays high after a beat so beats can follow back to back
	task automatic send(logic [3:0] a, logic [63:0] op, logic last);
		int n;
		if (!calm && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 10);
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
		item <= '{action: a, operand: op, last_instruction: last};
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// send a restart, then a random program-like mix of len instructions
	task automatic rand_program(int len);
		logic [3:0] a;
		logic [63:0] op;
		int k;
		send(A_RESTART, rand64(), 1'b0);
		for (k = 0; k < len; k++) begin
			case ($urandom_range(0, 11))
				0, 1: a = A_I32CONST;
				2: a = A_I64CONST;
				3: a = A_ADD;
				4: a = A_SUB;
				5: a = A_MUL;
				6: a = A_DIVS;
				7: a = A_LGET;
				8: a = A_LSET;
				9: a = A_DROP;
				10: a = A_NOP;
				default: a = ($urandom_range(0, 30) == 0) ?
					4'($urandom_range(8, 15)) : A_I32CONST;
			endcase
			op = rand64();
			if ((a == A_LGET || a == A_LSET) && $urandom_range(0, 9) != 0)
				op = {$urandom, 28'h0, 4'($urandom)} & 64'hffff_ffff_0000_000f;
			send(a, op, (k == len - 1) && $urandom_range(0, 1));
		end
	endtask

	initial begin
		int i;
		cycles = 0;
		calm = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: arithmetic extremes and special cases
		send(A_DROP, 0, 1'b0);
		send(A_ADD, 0, 1'b0);
		send(A_RESTART, 0, 1'b0);
		send(A_I32CONST, 64'h0000_0000_8000_0000, 1'b0);
		send(A_I32CONST, 64'hffff_ffff_ffff_ffff, 1'b0);
		send(A_DIVS, 0, 1'b0);
		send(A_I64CONST, 64'h8000_0000_0000_0000, 1'b0);
		send(A_I64CONST, 64'h7fff_ffff_ffff_ffff, 1'b0);
		send(A_MUL, 0, 1'b0);
		send(A_I32CONST, 7, 1'b0);
		send(A_I32CONST, -2, 1'b0);
		send(A_SUB, 0, 1'b0);
		send(A_I32CONST, 0, 1'b0);
		send(A_DIVS, 0, 1'b0);
		send(A_NOP, 0, 1'b0);
		send(A_RESTART, 0, 1'b0);
		send(A_I32CONST, 5, 1'b0);
		send(A_LSET, 64'hffff_ffff_0000_000f, 1'b0);
		send(A_LGET, 64'h0000_0000_0000_000f, 1'b0);
		send(A_LSET, 16, 1'b0);
		send(A_RESTART, 0, 1'b0);
		send(A_I32CONST, 1, 1'b0);
		send(A_ADD, 0, 1'b0);
		send(A_RESTART, 0, 1'b0);
		send(4'd15, 0, 1'b0);
		send(A_RESTART, 0, 1'b0);
		send(A_RETURN, 0, 1'b0);
		send(A_NOP, 0, 1'b0);

		// pause until everything drains
		push <= 1'b0;
		while (pending != 0) @(negedge clk);

		// overflow: fill the stack past its depth
		send(A_RESTART, 0, 1'b0);
		for (i = 0; i <= STACK_DEPTH; i++)
			send(A_I64CONST, rand64(), 1'b0);
		send(A_RESTART, 0, 1'b1);

		while (sent < 1900) begin
			if (sent > 1700) calm = 1'b1;
			if ($urandom_range(0, 9) == 0)
				send(4'($urandom), rand64(), 1'($urandom));
			else
				rand_program($urandom_range(2, 40));
		end
		calm = 1'b1;
		push <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("sent %0d instruction beats, checked %0d result beats", sent, beats_seen);
		$display("covered all opcodes, stack overflow/underflow, locals and divide corners");
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
